FILE: rtl/srtf_tick_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// srtf tick scheduler assertion macros
// Shorthand for clocked assertions that run under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef SRTF_TICK_SCHEDULER_UNIT_MACROS_SVH
`define SRTF_TICK_SCHEDULER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SRTF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types, widths and helpers of the srtf tick scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned SLOT_NUM_W    = 5;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_TDATA_W   = 104;
  localparam int unsigned BEST_W        = 17;

  localparam logic [TICK_W-1:0] TICK_MAX     = '1;
  localparam logic [BEST_W-1:0] NO_CANDIDATE = 17'd100000;

  // request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // one process slot as kept in the slot memory
  typedef struct packed {
    logic [TICK_W-1:0] first_run;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrival;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_rd;
    logic calc;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic empty;
    logic scan_last;
  } sts_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == TICK_MAX) ? v : v + TICK_W'(1);
  endfunction

endpackage

FILE: rtl/srtf_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_unit
// Shortest-remaining-time-first scheduler over NUM_SLOTS process slots.
// ----------------------------------------------------------------------------
//   channel  | dir | tuser           | tdata (low bit up)
//   s_axis   | in  | req_type (1=tick)| arrival_time[15:0], burst_time[15:0]
//   m_axis   | out | -               | running_slot[4:0], finished, response,
//            |     |                 | waiting, turnaround (32 bit each), 2 pad
//
// a tick walks the slot memory read port one slot per cycle over the loaded
// slots, then drains, calculates and finishes; the scan is skipped when empty
// loads produce no transaction; every tick produces one result transaction
// the result register frees the input side: a new item is taken while a
// result waits, a second result waits in the finish step until taken
// reset clears the time counter, fill count and started flags; no clear pass
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_unit #(
  parameter int unsigned NUM_SLOTS = srtf_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // arrival_time[15:0], burst_time[31:16]
  input  logic [srtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // running_slot[4:0], finished[5], response_ticks[37:6],
  // waiting_ticks[69:38], turnaround_ticks[101:70], zero pad[103:102]
  output logic [srtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  srtf_pkg::cmd_t cmd;
  srtf_pkg::sts_t sts;

  srtf_ctrl u_srtf_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srtf_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_srtf_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .m_tdata_o (m_axis_tdata_o)
  );

endmodule

FILE: rtl/srtf_ram.sv
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
  parameter int unsigned WIDTH = srtf_pkg::SLOT_W,
  parameter int unsigned DEPTH = srtf_pkg::NUM_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer of the scheduler: load, slot scan, result math and hand-off.
// ----------------------------------------------------------------------------
module srtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  srtf_pkg::sts_t      sts_i,
  output srtf_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q;
    cmd_o     = '0;
    if (out_vld_q && m_tready_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.is_tick) begin
            cmd_o.scan_start = 1'b1;
            // nothing loaded: skip the scan, the result is idle
            state_d = sts_i.empty ? ST_CALC : ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last slot read is compared here
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || m_tready_i) begin
          cmd_o.commit = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

FILE: rtl/srtf_dp.sv
// ----------------------------------------------------------------------------
// srtf_dp
// Slot memory, minimum-remaining-time scan, time counter and result math.
// ----------------------------------------------------------------------------
module srtf_dp #(
  parameter int unsigned NUM_SLOTS = srtf_pkg::NUM_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srtf_pkg::cmd_t                      cmd_i,
  output srtf_pkg::sts_t                      sts_o,
  input  logic [srtf_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic                                s_tuser_i,
  output logic [srtf_pkg::OUT_TDATA_W-1:0]    m_tdata_o
);

  localparam int unsigned IW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TW = srtf_pkg::TICK_W;
  localparam int unsigned DW = srtf_pkg::TIME_W;

  logic [TW-1:0]         now_q;
  logic [CW-1:0]         cnt_q;
  logic [NUM_SLOTS-1:0]  started_q;
  logic [IW-1:0]         scan_idx_q;
  logic                  cmp_vld_q;
  logic [IW-1:0]         cmp_idx_q;
  logic                  found_q;
  logic [srtf_pkg::BEST_W-1:0] best_val_q;
  logic [IW-1:0]         best_idx_q;
  srtf_pkg::slot_t       best_q;
  logic [TW-1:0]         fr_q, resp_q, wait_q;
  logic [DW-1:0]         rem_dec_q;
  logic                  fin_q;
  logic [srtf_pkg::OUT_TDATA_W-1:0] out_q;

  logic [DW-1:0]         arr_in, bur_in;
  logic                  full, load_wr, upd_wr, qualify;
  srtf_pkg::slot_t       rd_slot, wr_slot;
  logic [IW-1:0]         waddr;
  logic [TW-1:0]         fr, a32, ab, done, resp, wait_t, turn;
  logic [TW:0]           turn_sum;
  logic [CW-1:0]         slot_p1;
  logic [srtf_pkg::SLOT_NUM_W-1:0] slot_num;

  assign arr_in = s_tdata_i[DW-1:0];
  assign bur_in = s_tdata_i[2*DW-1:DW];

  assign full    = (cnt_q == CW'(NUM_SLOTS));
  assign load_wr = cmd_i.load && !full;
  assign upd_wr  = cmd_i.commit && found_q;

  assign sts_o.is_tick   = (s_tuser_i == srtf_pkg::REQ_TICK);
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.scan_last = (CW'(scan_idx_q) == cnt_q - CW'(1));

  always_comb begin
    if (cmd_i.commit) begin
      waddr             = best_idx_q;
      wr_slot.first_run = fr_q;
      wr_slot.remaining = rem_dec_q;
      wr_slot.burst     = best_q.burst;
      wr_slot.arrival   = best_q.arrival;
    end else begin
      waddr             = cnt_q[IW-1:0];
      wr_slot.first_run = '0;
      wr_slot.remaining = bur_in;
      wr_slot.burst     = bur_in;
      wr_slot.arrival   = arr_in;
    end
  end

  srtf_ram #(
    .WIDTH (srtf_pkg::SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_srtf_ram (
    .clk_i   (clk_i),
    .we_i    (load_wr || upd_wr),
    .waddr_i (waddr),
    .wdata_i (wr_slot),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_slot)
  );

  // arrived, not done, and strictly shorter keeps the lowest slot on ties
  assign qualify = cmp_vld_q && (TW'(rd_slot.arrival) <= now_q) &&
                   (rd_slot.remaining != '0) &&
                   ({1'b0, rd_slot.remaining} < best_val_q);

  // result math for the chosen slot
  always_comb begin
    fr     = started_q[best_idx_q] ? best_q.first_run : now_q;
    a32    = TW'(best_q.arrival);
    resp   = (fr >= a32) ? fr - a32 : '0;
    ab     = a32 + TW'(best_q.burst);
    done   = srtf_pkg::sat_inc(now_q);
    wait_t = (done >= ab) ? done - ab : '0;
  end

  assign turn_sum = {1'b0, wait_q} + (TW + 1)'(best_q.burst);
  assign turn     = turn_sum[TW] ? srtf_pkg::TICK_MAX : turn_sum[TW-1:0];
  assign slot_p1  = CW'(best_idx_q) + CW'(1);
  assign slot_num = srtf_pkg::SLOT_NUM_W'(slot_p1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      cnt_q      <= '0;
      started_q  <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      best_val_q <= srtf_pkg::NO_CANDIDATE;
    end else begin
      if (load_wr) begin
        started_q[cnt_q[IW-1:0]] <= 1'b0;
        cnt_q                    <= cnt_q + CW'(1);
      end
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        best_val_q <= srtf_pkg::NO_CANDIDATE;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_idx_q <= scan_idx_q + IW'(1);
        end
        if (qualify) begin
          found_q    <= 1'b1;
          best_val_q <= {1'b0, rd_slot.remaining};
        end
      end
      if (cmd_i.commit) begin
        now_q <= srtf_pkg::sat_inc(now_q);
        if (found_q) begin
          started_q[best_idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_idx_q;
    if (qualify) begin
      best_idx_q <= cmp_idx_q;
      best_q     <= rd_slot;
    end
    if (cmd_i.calc) begin
      fr_q      <= fr;
      resp_q    <= resp;
      wait_q    <= wait_t;
      rem_dec_q <= best_q.remaining - DW'(1);
      fin_q     <= (best_q.remaining == DW'(1));
    end
    if (cmd_i.commit) begin
      if (!found_q) begin
        out_q <= '0;
      end else if (fin_q) begin
        out_q <= {2'b00, turn, wait_q, resp_q, 1'b1, slot_num};
      end else begin
        out_q <= {{(srtf_pkg::OUT_TDATA_W - srtf_pkg::SLOT_NUM_W){1'b0}}, slot_num};
      end
    end
  end

  assign m_tdata_o = out_q;

endmodule

FILE: rtl/srtf_chk.sv
// ----------------------------------------------------------------------------
// srtf_chk
// Port-level checks of the srtf tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "srtf_tick_scheduler_unit_macros.svh"

module srtf_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [srtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                             s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [srtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result transaction holds
  `SRTF_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")

  // a tick keeps the input side busy for at least the next cycle
  `SRTF_ASSERT_NEXT(a_tick_busy,
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == srtf_pkg::REQ_TICK),
    !s_axis_tready_o, "input ready right after a tick")

  // timing fields are zero unless the process finished
  `SRTF_ASSERT_SAME(a_times_zero, m_axis_tvalid_o && !m_axis_tdata_o[5],
    m_axis_tdata_o[101:6] == '0, "timing fields set without completion")

  // turnaround covers the waiting time
  `SRTF_ASSERT_SAME(a_turn_ge_wait, m_axis_tvalid_o && m_axis_tdata_o[5],
    m_axis_tdata_o[101:70] >= m_axis_tdata_o[69:38], "turnaround below waiting")

endmodule

bind srtf_tick_scheduler_unit srtf_chk u_srtf_chk (.*);
